[rtl/dcp_pkg.sv]
// Package: DES tables, register indexes and permutation helpers.
package dcp_pkg;

  localparam int RoundCount = 16;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] REG_KEY = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IV = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MODE = 2'd2;
  localparam logic [63:0] PAD_EIGHTS = 64'h0808080808080808;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef logic [63:0] block_t;

  localparam byte unsigned IPERM [64] = '{
    58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
  localparam byte unsigned FPERM [64] = '{
    40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
  localparam byte unsigned EXPAND [48] = '{
    32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
    16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
  localparam byte unsigned PPERM [32] = '{
    16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
  localparam byte unsigned KPERM1 [56] = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam byte unsigned KPERM2 [48] = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam byte unsigned ROTS [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam byte unsigned SBOX [8][64] = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-IPERM[i]];
    return r;
  endfunction

  function automatic logic [63:0] fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64-FPERM[i]];
    return r;
  endfunction

  function automatic logic [55:0] pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64-KPERM1[i]];
    return r;
  endfunction

  function automatic logic [47:0] pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56-KPERM2[i]];
    return r;
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-EXPAND[i]];
    e = e ^ k;
    for (int s = 0; s < 8; s++) begin
      six = e[47-6*s -: 6];
      o[31-4*s -: 4] = SBOX[s][{six[5], six[0], six[4:1]}][3:0];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32-PPERM[i]];
    return p;
  endfunction

  function automatic logic [27:0] rotl(input logic [27:0] v, input logic two);
    return two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
  endfunction

  function automatic logic [27:0] rotr(input logic [27:0] v, input logic two);
    return two ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
  endfunction

  function automatic logic [63:0] lead_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) m[63-8*i -: 8] = (4'(i) < n) ? BYTE_ONES : 8'h00;
    return m;
  endfunction

endpackage

[rtl/dcp_if.sv]
// Interfaces: input and result channels.
interface dcp_in_if;
  logic valid;
  logic ready;
  logic [63:0] data_block;
  logic [3:0] valid_bytes;
  logic final_block;
  modport source (output valid, data_block, valid_bytes, final_block, input ready);
  modport sink (input valid, data_block, valid_bytes, final_block, output ready);
endinterface

interface dcp_out_if;
  logic valid;
  logic ready;
  logic [63:0] result_block;
  logic [3:0] result_bytes;
  logic result_last;
  modport source (output valid, result_block, result_bytes, result_last, input ready);
  modport sink (input valid, result_block, result_bytes, result_last, output ready);
endinterface

[rtl/des_cbc_pkcs5_engine_core.sv]
// Top level: DES-CBC engine with PKCS5 padding and removal.
// One DES round per cycle on a single shared round unit; subkeys are made on the fly
// by rotating the C/D key halves (left for encrypt, right for decrypt). A block is
// loaded on its accepting edge, runs 16 rounds, and its result is registered on the
// next edge. The next block can be accepted once that result is taken. A full final
// encrypt block runs the pad block after its first result is taken.
// One block at a time; ready is low while a block is in work or a result waits.
module des_cbc_pkcs5_engine_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [dcp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [dcp_pkg::CfgDataW-1:0] cfg_data,
  dcp_in_if.sink in_ch,
  dcp_out_if.source out_ch
);
  import dcp_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_OUT = 2'd2;

  logic [63:0] cipher_key, init_vector, chain_value, cipher_in;
  logic decrypt_mode, in_message, dec, fin, pad_next_blk;
  logic [1:0] state;
  logic [3:0] round, nbytes;
  logic [31:0] lh, rh;
  logic [27:0] ch, dh, c_use, d_use;
  logic [55:0] cd0;
  logic [63:0] des_out, chain_cur, plain, res;
  logic [7:0] pad;
  logic [3:0] keep_n;
  logic rot2;
  logic [63:0] cipher_hold;

  assign cd0 = pc1(cipher_key);
  assign rot2 = ROTS[round] == 8'd2;
  assign c_use = dec ? ch : rotl(ch, rot2);
  assign d_use = dec ? dh : rotl(dh, rot2);
  assign des_out = fp({rh, lh});
  assign chain_cur = in_message ? chain_value : init_vector;
  assign keep_n = (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
  assign plain = des_out ^ chain_value;
  assign pad = plain[7:0];
  assign in_ch.ready = (state == ST_IDLE);

  always_comb begin
    if (decrypt_mode) begin
      cipher_in = in_ch.data_block;
    end else if (!in_ch.final_block || keep_n == 4'd8) begin
      cipher_in = in_ch.data_block ^ chain_cur;
    end else begin
      cipher_in = ((in_ch.data_block & lead_mask(keep_n)) |
                   ({8{4'd0, 4'd8 - keep_n}} & ~lead_mask(keep_n))) ^ chain_cur;
    end
  end

  always_comb begin
    res = des_out;
    nbytes = 4'd8;
    if (dec && fin) begin
      if (pad < 8'd8) begin
        nbytes = 4'd8 - pad[3:0];
        res = plain & lead_mask(nbytes);
      end else begin
        nbytes = 4'd0;
        res = '0;
      end
    end else if (dec) begin
      res = plain;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      init_vector <= '0;
      decrypt_mode <= 1'b0;
      in_message <= 1'b0;
      state <= ST_IDLE;
      out_ch.valid <= 1'b0;
      round <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY: cipher_key <= cfg_data;
          REG_IV: init_vector <= cfg_data;
          REG_MODE: decrypt_mode <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: if (in_ch.valid) begin
          in_message <= !in_ch.final_block;
          dec <= decrypt_mode;
          fin <= in_ch.final_block;
          pad_next_blk <= !decrypt_mode && in_ch.final_block && keep_n == 4'd8;
          if (decrypt_mode) chain_value <= chain_cur;
          {lh, rh} <= ip(cipher_in);
          ch <= cd0[55:28];
          dh <= cd0[27:0];
          round <= '0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          lh <= rh;
          rh <= lh ^ feistel(rh, pc2({c_use, d_use}));
          ch <= dec ? rotr(ch, ROTS[4'd15 - round] == 8'd2) : c_use;
          dh <= dec ? rotr(dh, ROTS[4'd15 - round] == 8'd2) : d_use;
          round <= round + 4'd1;
          if (round == 4'(RoundCount - 1)) state <= ST_OUT;
        end
        ST_OUT: if (!out_ch.valid) begin
          out_ch.valid <= 1'b1;
          out_ch.result_block <= res;
          out_ch.result_bytes <= nbytes;
          out_ch.result_last <= fin && !pad_next_blk;
          chain_value <= dec ? cipher_hold : des_out;
        end else if (out_ch.ready) begin
          out_ch.valid <= 1'b0;
          if (pad_next_blk) begin
            pad_next_blk <= 1'b0;
            {lh, rh} <= ip(PAD_EIGHTS ^ out_ch.result_block);
            ch <= cd0[55:28];
            dh <= cd0[27:0];
            round <= '0;
            state <= ST_RUN;
          end else begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_ch.valid) cipher_hold <= in_ch.data_block;
  end

endmodule

[dv/des_cbc_pkcs5_engine_core_test.sv]
// Testbench for the DES-CBC PKCS5 engine: random and directed messages checked against a predictor.
`timescale 1ns / 100ps

module des_cbc_pkcs5_engine_core_test;
  import dcp_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic [63:0] data;
    logic [3:0] nbytes;
    logic fin;
  } blk_item_t;

  typedef struct {
    logic [63:0] blk;
    logic [3:0] nbytes;
    logic last;
  } res_item_t;

  typedef struct {
    logic [63:0] chain;
    logic [63:0] iv;
    bit dec;
    bit busy;
  } cbc_state_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  dcp_in_if in_ch();
  dcp_out_if out_ch();

  des_cbc_pkcs5_engine_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  blk_item_t pending_q[$];
  res_item_t expected_q[$];
  cbc_state_t engine;
  logic [47:0] subkey [16];
  int n_items;
  int errors;
  int src_idle_pct;
  int snk_idle_pct;
  bit hold_req;
  bit hold_done;
  int hold_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void load_key(logic [63:0] key);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [55:0] cat;
    for (int i = 0; i < 56; i++) cd[55-i] = key[64-KPERM1[i]];
    c = cd[55:28];
    d = cd[27:0];
    for (int r = 0; r < RoundCount; r++) begin
      for (int s = 0; s < ROTS[r]; s++) begin
        c = {c[26:0], c[27]};
        d = {d[26:0], d[27]};
      end
      cat = {c, d};
      for (int j = 0; j < 48; j++) subkey[r][47-j] = cat[56-KPERM2[j]];
    end
  endfunction

  function automatic logic [31:0] round_fn(logic [31:0] r, logic [47:0] k);
    logic [47:0] e;
    logic [31:0] o;
    logic [31:0] p;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-EXPAND[i]];
    e ^= k;
    for (int s = 0; s < 8; s++) begin
      six = e[47-6*s -: 6];
      o[31-4*s -: 4] = SBOX[s][{six[5], six[0]} * 16 + six[4:1]][3:0];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[32-PPERM[i]];
    return p;
  endfunction

  function automatic logic [63:0] des_crypt(logic [63:0] blk, bit dec);
    logic [63:0] v;
    logic [63:0] w;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    for (int i = 0; i < 64; i++) v[63-i] = blk[64-IPERM[i]];
    l = v[63:32];
    r = v[31:0];
    for (int i = 0; i < RoundCount; i++) begin
      t = r;
      r = l ^ round_fn(r, dec ? subkey[RoundCount-1-i] : subkey[i]);
      l = t;
    end
    v = {r, l};
    for (int i = 0; i < 64; i++) w[63-i] = v[64-FPERM[i]];
    return w;
  endfunction

  function automatic logic [63:0] keep_bytes(int n);
    return (n == 0) ? 64'd0 : ~64'd0 << (8 * (8 - n));
  endfunction

  function automatic void cbc_step(ref cbc_state_t st, input blk_item_t it, ref res_item_t q[$]);
    int n;
    int pad;
    logic [63:0] res;
    logic [63:0] keep;
    if (!st.busy) st.chain = st.iv;
    st.busy = !it.fin;
    n = (it.nbytes > 8) ? 8 : it.nbytes;
    if (st.dec) begin
      res = des_crypt(it.data, 1'b1) ^ st.chain;
      st.chain = it.data;
      pad = res[7:0];
      if (!it.fin) q.push_back('{res, 4'd8, 1'b0});
      else if (pad < 8) q.push_back('{res & keep_bytes(8 - pad), 4'(8 - pad), 1'b1});
      else q.push_back('{64'd0, 4'd0, 1'b1});
    end else if (!it.fin || n == 8) begin
      st.chain = des_crypt(it.data ^ st.chain, 1'b0);
      q.push_back('{st.chain, 4'd8, 1'b0});
      if (it.fin) begin
        st.chain = des_crypt(PAD_EIGHTS ^ st.chain, 1'b0);
        q.push_back('{st.chain, 4'd8, 1'b1});
      end
    end else begin
      keep = keep_bytes(n);
      res = (it.data & keep) | ((64'(8 - n) * 64'h0101010101010101) & ~keep);
      st.chain = des_crypt(res ^ st.chain, 1'b0);
      q.push_back('{st.chain, 4'd8, 1'b1});
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data_block <= '0;
      in_ch.valid_bytes <= '0;
      in_ch.final_block <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        cbc_step(engine, '{in_ch.data_block, in_ch.valid_bytes, in_ch.final_block}, expected_q);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.data_block <= pending_q[0].data;
          in_ch.valid_bytes <= pending_q[0].nbytes;
          in_ch.final_block <= pending_q[0].fin;
          void'(pending_q.pop_front());
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    res_item_t e;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h/%0d/%0d", out_ch.result_block,
                                     out_ch.result_bytes, out_ch.result_last);
        end else begin
          e = expected_q.pop_front();
          if (e.blk !== out_ch.result_block || e.nbytes !== out_ch.result_bytes ||
              e.last !== out_ch.result_last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d", e.blk, e.nbytes,
                       e.last, out_ch.result_block, out_ch.result_bytes, out_ch.result_last);
          end
        end
      end
      if (hold_req && !hold_done && hold_cnt == 0) begin
        hold_cnt <= 400;
        hold_done <= 1'b1;
        out_ch.ready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_KEY: load_key(val);
      REG_IV: engine.iv = val;
      REG_MODE: engine.dec = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic add_block(logic [63:0] data, logic [3:0] nb, logic fin);
    pending_q.push_back('{data, nb, fin});
    n_items++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // ciphertext of a plaintext list, chained from the current IV, no padding added
  task automatic add_dec_plain(logic [63:0] plain[$], bit corrupt);
    logic [63:0] c;
    int bad;
    c = engine.iv;
    bad = corrupt ? $urandom_range(plain.size() - 1) : -1;
    foreach (plain[i]) begin
      c = des_crypt(plain[i] ^ c, 1'b0);
      add_block((i == bad) ? c ^ (64'd1 << $urandom_range(63)) : c, 4'($urandom_range(15)),
                i == plain.size() - 1);
    end
  endtask

  task automatic add_enc_msg(int nb);
    int r;
    for (int i = 0; i < nb - 1; i++) add_block(rand64(), 4'($urandom_range(15)), 1'b0);
    r = $urandom_range(11);
    add_block(rand64(), (r > 8) ? 4'($urandom_range(9, 15)) : 4'(r), 1'b1);
  endtask

  task automatic add_dec_msg(int nb);
    logic [63:0] plain[$];
    for (int i = 0; i < nb; i++) plain.push_back(rand64());
    if ($urandom_range(9) < 8) plain[nb-1][7:0] = 8'($urandom_range(1, 8));
    add_dec_plain(plain, $urandom_range(9) == 0);
  endtask

  initial begin
    logic [63:0] plain[$];
    int r;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data_block = '0;
    in_ch.valid_bytes = '0;
    in_ch.final_block = 1'b0;
    out_ch.ready = 1'b0;
    engine = '{64'd0, 64'd0, 1'b0, 1'b0};
    load_key(64'd0);
    n_items = 0;
    errors = 0;
    src_idle_pct = 24;
    snk_idle_pct = 74;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // encrypt under reset configuration
    add_block(64'd0, 4'd8, 1'b1);
    add_block(~64'd0, 4'd0, 1'b1);
    add_block(rand64(), 4'd3, 1'b0);
    add_block(rand64(), 4'd15, 1'b1);
    for (int n = 1; n < 8; n++) add_block(~64'd0, 4'(n), 1'b1);
    drain();
    cfg_write(REG_KEY, rand64());
    cfg_write(REG_IV, ~64'd0);
    cfg_write(REG_MODE, 64'd1);
    cfg_write(REG_UNUSED, rand64());
    // pad byte zero, eight, all ones, then a proper two-block message
    plain = '{64'h0123456789abcd00};
    add_dec_plain(plain, 1'b0);
    plain = '{rand64() & ~64'hff | 64'h08};
    add_dec_plain(plain, 1'b0);
    plain = '{rand64() | 64'hff};
    add_dec_plain(plain, 1'b0);
    plain = '{rand64(), rand64() & ~64'hff | 64'h03};
    add_dec_plain(plain, 1'b0);
    add_block(rand64(), 4'd0, 1'b1);
    drain();

    for (int p = 0; n_items < 1350; p++) begin
      src_idle_pct = (p < 4) ? 24 : (p < 7) ? 74 : 0;
      snk_idle_pct = (p < 4) ? 74 : (p < 7) ? 24 : 0;
      cfg_write(REG_KEY, (p == 0) ? 64'd0 : (p == 1) ? ~64'd0 : rand64());
      cfg_write(REG_IV, (p % 3 == 0) ? 64'd0 : (p % 3 == 1) ? ~64'd0 : rand64());
      cfg_write(REG_MODE, 64'(p % 2));
      cfg_write(REG_UNUSED, rand64());
      if (p == 2) hold_req = 1'b1;
      for (int m = 0; m < 60 && n_items < 1350; m++) begin
        r = $urandom_range(9);
        if (p % 2 == 0) add_enc_msg($urandom_range(1, 4));
        else if (r < 8) add_dec_msg($urandom_range(1, 4));
        else for (int i = 0; i < 2; i++) add_block(rand64(), 4'($urandom_range(15)), i == 1);
      end
      drain();
    end

    errors += expected_q.size();
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[des_cbc_pkcs5_engine_core.f]
rtl/dcp_pkg.sv
rtl/dcp_if.sv
rtl/des_cbc_pkcs5_engine_core.sv
dv/des_cbc_pkcs5_engine_core_test.sv
